/* rtl/dcmrd_pkg.sv */
`default_nettype none

package dcmrd_pkg;

  // Backing block sizes in bytes
  localparam int unsigned MAIN_RAM_BYTES    = 4194304;
  localparam int unsigned SHARED_WRAM_BYTES = 32768;
  localparam int unsigned SECOND_WRAM_BYTES = 65536;
  localparam int unsigned DTCM_PHYS_BYTES   = 16384;

  // Field widths
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned REGION_W  = 4;
  localparam int unsigned TCM_W     = 26;
  localparam int unsigned SWRAM_W   = 15;
  localparam int unsigned WIN_W     = 23;
  localparam int unsigned OFS_W     = 23;
  localparam int unsigned CFG_IDX_W = 3;

  // Shared WRAM remainder pipeline
  localparam int unsigned NUM_W      = 24;
  localparam int unsigned REM_W      = 24;
  localparam int unsigned PART_W     = SWRAM_W;
  localparam int unsigned DEN_W      = SWRAM_W + 1;
  localparam int unsigned DIV_BITS   = 2;
  localparam int unsigned DIV_STAGES = NUM_W / DIV_BITS;

  // Fixed map addresses
  localparam logic [ADDR_W-1:0] MAIN_RAM_BASE = 32'h0200_0000;
  localparam logic [ADDR_W-1:0] SWRAM_BASE    = 32'h0300_0000;
  localparam logic [ADDR_W-1:0] WRAM7_HI_BASE = 32'h0380_0000;
  localparam logic [ADDR_W-1:0] BIOS7_LIMIT   = 32'h0000_4000;
  localparam logic [19:0]       BIOS9_PAGE    = 20'hFFFF0;

  // Region codes
  localparam logic [REGION_W-1:0] RGN_OTHER   = 4'd0;
  localparam logic [REGION_W-1:0] RGN_ITCM    = 4'd1;
  localparam logic [REGION_W-1:0] RGN_DTCM    = 4'd2;
  localparam logic [REGION_W-1:0] RGN_BIOS9   = 4'd3;
  localparam logic [REGION_W-1:0] RGN_MAINRAM = 4'd4;
  localparam logic [REGION_W-1:0] RGN_SWRAM   = 4'd5;
  localparam logic [REGION_W-1:0] RGN_IO9     = 4'd6;
  localparam logic [REGION_W-1:0] RGN_VRAM    = 4'd7;
  localparam logic [REGION_W-1:0] RGN_BIOS7   = 4'd8;
  localparam logic [REGION_W-1:0] RGN_WRAM7   = 4'd9;
  localparam logic [REGION_W-1:0] RGN_IO7     = 4'd10;
  localparam logic [REGION_W-1:0] RGN_WIFI    = 4'd11;
  localparam logic [REGION_W-1:0] RGN_VWRAM   = 4'd12;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ITCM_SIZE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DTCM_BASE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DTCM_SIZE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SWRAM9_MASK   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SWRAM9_OFFSET = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SWRAM7_MASK   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SWRAM7_OFFSET = 3'd6;

  typedef struct packed {
    logic [TCM_W-1:0]   itcm_size;
    logic [ADDR_W-1:0]  dtcm_base;
    logic [TCM_W-1:0]   dtcm_size;
    logic [SWRAM_W-1:0] swram9_mask;
    logic [SWRAM_W-1:0] swram9_offset;
    logic [SWRAM_W-1:0] swram7_mask;
    logic [SWRAM_W-1:0] swram7_offset;
  } cfg_t;

  typedef struct packed {
    logic [REGION_W-1:0] region;
    logic                mappable;
    logic [ADDR_W-1:0]   addr;
    logic [WIN_W-1:0]    window;
    logic [OFS_W-1:0]    offset;
    logic [REM_W-1:0]    rem;
    logic                div_en;
    logic [NUM_W-1:0]    num;
    logic [DEN_W-1:0]    den;
    logic [PART_W-1:0]   part;
  } pipe_t;

endpackage

`default_nettype wire

/* rtl/dual_cpu_memory_region_decoder.sv */
// Channel   Direction  Handshake                      Payload
// request   in         start_i, busy_o                cpu_i, addr_i
// config    in         cfg_valid_i, cfg_ready_o       cfg_index_i, cfg_data_i
// result    out        result_valid_o (strobe)        region_code_o, mappable_o,
//                                                     mirror_start_o, window_size_o,
//                                                     block_offset_o
//
// One request per cycle; busy_o stays low and cfg_ready_o stays high.
// Results leave in request order after these registers: input register, decode,
// 12-stage shared WRAM remainder pipeline (2 bits per stage), output register.
// Async active-low reset clears all valid bits and the config registers.
// The result side cannot stall; each result is shown for one cycle only.
`default_nettype none

module dual_cpu_memory_region_decoder
  import dcmrd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic                 cpu_i,
  input  wire logic [ADDR_W-1:0]    addr_i,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [ADDR_W-1:0]    cfg_data_i,
  output logic                      result_valid_o,
  output logic [REGION_W-1:0]       region_code_o,
  output logic                      mappable_o,
  output logic [ADDR_W-1:0]         mirror_start_o,
  output logic [WIN_W-1:0]          window_size_o,
  output logic [OFS_W-1:0]          block_offset_o
);

  cfg_t              cfg;
  logic              in_valid_q, in_cpu_q;
  logic [ADDR_W-1:0] in_addr_q;
  logic [DIV_STAGES:0] stg_valid;
  pipe_t             stg_pipe [DIV_STAGES+1];
  pipe_t             last;
  logic [REM_W-1:0]  rem_fin;

  logic                res_valid_q, res_map_q;
  logic [REGION_W-1:0] res_region_q;
  logic [ADDR_W-1:0]   res_mirror_q;
  logic [WIN_W-1:0]    res_window_q;
  logic [OFS_W-1:0]    res_offset_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  dcmrd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      in_cpu_q  <= cpu_i;
      in_addr_q <= addr_i;
    end
  end

  dcmrd_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (in_valid_q),
    .cpu_i   (in_cpu_q),
    .addr_i  (in_addr_q),
    .valid_o (stg_valid[0]),
    .pipe_o  (stg_pipe[0])
  );

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    dcmrd_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[k]),
      .pipe_i  (stg_pipe[k]),
      .valid_o (stg_valid[k+1]),
      .pipe_o  (stg_pipe[k+1])
    );
  end

  assign last    = stg_pipe[DIV_STAGES];
  assign rem_fin = last.div_en ? REM_W'(last.part) : last.rem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= stg_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    res_region_q <= last.region;
    res_map_q    <= last.mappable;
    if (last.mappable) begin
      res_mirror_q <= last.addr - ADDR_W'(rem_fin);
      res_window_q <= last.window;
      res_offset_q <= last.offset;
    end else begin
      res_mirror_q <= '0;
      res_window_q <= '0;
      res_offset_q <= '0;
    end
  end

  assign result_valid_o = res_valid_q;
  assign region_code_o  = res_region_q;
  assign mappable_o     = res_map_q;
  assign mirror_start_o = res_mirror_q;
  assign window_size_o  = res_window_q;
  assign block_offset_o = res_offset_q;

  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##15 result_valid_o)
    else $error("request did not produce a result after 15 cycles");

  a_latency_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o, 15))
    else $error("result strobe without a matching request");

  a_map_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && mappable_o |->
      (region_code_o == RGN_DTCM || region_code_o == RGN_MAINRAM ||
       region_code_o == RGN_SWRAM || region_code_o == RGN_WRAM7))
    else $error("mappable flag on a region without backing memory");

  a_map_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && mappable_o |-> window_size_o != '0)
    else $error("mappable result with empty window");

endmodule

`default_nettype wire

/* rtl/dcmrd_cfg_regs.sv */
`default_nettype none

module dcmrd_cfg_regs
  import dcmrd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 wr_en_i,
  input  wire logic [CFG_IDX_W-1:0] wr_index_i,
  input  wire logic [ADDR_W-1:0]    wr_data_i,
  output cfg_t                      cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en_i) begin
      case (wr_index_i)
        CFG_ITCM_SIZE:     cfg_q.itcm_size     <= wr_data_i[TCM_W-1:0];
        CFG_DTCM_BASE:     cfg_q.dtcm_base     <= wr_data_i;
        CFG_DTCM_SIZE:     cfg_q.dtcm_size     <= wr_data_i[TCM_W-1:0];
        CFG_SWRAM9_MASK:   cfg_q.swram9_mask   <= wr_data_i[SWRAM_W-1:0];
        CFG_SWRAM9_OFFSET: cfg_q.swram9_offset <= wr_data_i[SWRAM_W-1:0];
        CFG_SWRAM7_MASK:   cfg_q.swram7_mask   <= wr_data_i[SWRAM_W-1:0];
        CFG_SWRAM7_OFFSET: cfg_q.swram7_offset <= wr_data_i[SWRAM_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/dcmrd_decode.sv */
`default_nettype none

module dcmrd_decode
  import dcmrd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfg_t              cfg_i,
  input  wire logic              valid_i,
  input  wire logic              cpu_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  output logic                   valid_o,
  output pipe_t                  pipe_o
);

  logic              valid_q;
  pipe_t             pipe_d, pipe_q;
  logic              itcm_hit, dtcm_hit, sw9_on, sw7_on;
  logic [ADDR_W:0]   dtcm_end;
  logic [ADDR_W-1:0] rel_dtcm, rel_main, rel_sw, rel_w7;
  logic [REGION_W-1:0] region;

  assign sw9_on   = cfg_i.swram9_mask != '0;
  assign sw7_on   = cfg_i.swram7_mask != '0;
  assign itcm_hit = addr_i < {{(ADDR_W-TCM_W){1'b0}}, cfg_i.itcm_size};
  assign dtcm_end = {1'b0, cfg_i.dtcm_base} + {{(ADDR_W+1-TCM_W){1'b0}}, cfg_i.dtcm_size};
  assign dtcm_hit = (addr_i >= cfg_i.dtcm_base) && ({1'b0, addr_i} < dtcm_end);

  assign rel_dtcm = addr_i - cfg_i.dtcm_base;
  assign rel_main = addr_i - MAIN_RAM_BASE;
  assign rel_sw   = addr_i - SWRAM_BASE;
  assign rel_w7   = addr_i - (sw7_on ? WRAM7_HI_BASE : SWRAM_BASE);

  always_comb begin
    region = RGN_OTHER;
    if (!cpu_i) begin
      if (itcm_hit) begin
        region = RGN_ITCM;
      end else if (dtcm_hit) begin
        region = RGN_DTCM;
      end else if (addr_i[31:12] == BIOS9_PAGE) begin
        region = RGN_BIOS9;
      end else begin
        case (addr_i[31:24])
          8'h02:   region = RGN_MAINRAM;
          8'h03:   region = sw9_on ? RGN_SWRAM : RGN_OTHER;
          8'h04:   region = RGN_IO9;
          8'h06:   region = RGN_VRAM;
          default: region = RGN_OTHER;
        endcase
      end
    end else begin
      if (addr_i < BIOS7_LIMIT) begin
        region = RGN_BIOS7;
      end else begin
        case (addr_i[31:23])
          9'h004, 9'h005: region = RGN_MAINRAM;
          9'h006:         region = sw7_on ? RGN_SWRAM : RGN_WRAM7;
          9'h007:         region = RGN_WRAM7;
          9'h008:         region = RGN_IO7;
          9'h009:         region = RGN_WIFI;
          9'h00C, 9'h00D: region = RGN_VWRAM;
          default:        region = RGN_OTHER;
        endcase
      end
    end
  end

  always_comb begin
    pipe_d          = '0;
    pipe_d.region   = region;
    pipe_d.addr     = addr_i;
    pipe_d.den      = DEN_W'(1);
    case (region)
      RGN_DTCM: begin
        pipe_d.mappable = 1'b1;
        pipe_d.window   = WIN_W'(DTCM_PHYS_BYTES);
        pipe_d.offset   = OFS_W'(MAIN_RAM_BYTES + SHARED_WRAM_BYTES + SECOND_WRAM_BYTES);
        pipe_d.rem      = rel_dtcm[REM_W-1:0] & REM_W'(DTCM_PHYS_BYTES - 1);
      end
      RGN_MAINRAM: begin
        pipe_d.mappable = 1'b1;
        pipe_d.window   = WIN_W'(MAIN_RAM_BYTES);
        pipe_d.rem      = rel_main[REM_W-1:0] & REM_W'(MAIN_RAM_BYTES - 1);
      end
      RGN_SWRAM: begin
        pipe_d.mappable = 1'b1;
        pipe_d.div_en   = 1'b1;
        pipe_d.num      = rel_sw[NUM_W-1:0];
        if (!cpu_i) begin
          pipe_d.den    = DEN_W'(cfg_i.swram9_mask) + DEN_W'(1);
          pipe_d.offset = OFS_W'(MAIN_RAM_BYTES) + OFS_W'(cfg_i.swram9_offset);
        end else begin
          pipe_d.den    = DEN_W'(cfg_i.swram7_mask) + DEN_W'(1);
          pipe_d.offset = OFS_W'(MAIN_RAM_BYTES) + OFS_W'(cfg_i.swram7_offset);
        end
        pipe_d.window   = WIN_W'(pipe_d.den);
      end
      RGN_WRAM7: begin
        pipe_d.mappable = 1'b1;
        pipe_d.window   = WIN_W'(SECOND_WRAM_BYTES);
        pipe_d.offset   = OFS_W'(MAIN_RAM_BYTES + SHARED_WRAM_BYTES);
        pipe_d.rem      = rel_w7[REM_W-1:0] & REM_W'(SECOND_WRAM_BYTES - 1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_q <= pipe_d;
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;

endmodule

`default_nettype wire

/* rtl/dcmrd_div_stage.sv */
`default_nettype none

module dcmrd_div_stage
  import dcmrd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  input  wire pipe_t pipe_i,
  output logic       valid_o,
  output pipe_t      pipe_o
);

  logic  valid_q;
  pipe_t pipe_d, pipe_q;

  // restoring remainder, DIV_BITS numerator bits per stage, MSB first
  always_comb begin
    logic [DEN_W-1:0] trial;
    pipe_d = pipe_i;
    for (int j = 0; j < DIV_BITS; j++) begin
      trial      = {pipe_d.part, pipe_d.num[NUM_W-1]};
      pipe_d.num = {pipe_d.num[NUM_W-2:0], 1'b0};
      if (trial >= pipe_d.den) begin
        trial = trial - pipe_d.den;
      end
      pipe_d.part = trial[PART_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_q <= pipe_d;
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;

endmodule

`default_nettype wire

/* bench/tb_dual_cpu_memory_region_decoder.sv */
module tb_dual_cpu_memory_region_decoder;
  import dcmrd_pkg::*;

  localparam int RESULT_LATENCY = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  typedef struct packed {
    logic              cpu;
    logic [ADDR_W-1:0] addr;
  } access_t;

  typedef struct packed {
    logic [REGION_W-1:0] region;
    logic                mappable;
    logic [ADDR_W-1:0]   mirror;
    logic [WIN_W-1:0]    window;
    logic [OFS_W-1:0]    offset;
  } decode_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 cpu_i = 1'b0;
  logic [ADDR_W-1:0]    addr_i = '0;
  logic                 cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [ADDR_W-1:0]    cfg_data_i = '0;
  logic                 busy_o;
  logic                 cfg_ready_o;
  logic                 result_valid_o;
  logic [REGION_W-1:0]  region_code_o;
  logic                 mappable_o;
  logic [ADDR_W-1:0]    mirror_start_o;
  logic [WIN_W-1:0]     window_size_o;
  logic [OFS_W-1:0]     block_offset_o;

  // shadow of the decoder's map registers
  logic [TCM_W-1:0]   map_itcm_size = '0;
  logic [ADDR_W-1:0]  map_dtcm_base = '0;
  logic [TCM_W-1:0]   map_dtcm_size = '0;
  logic [SWRAM_W-1:0] map_swram9_mask = '0;
  logic [SWRAM_W-1:0] map_swram9_offset = '0;
  logic [SWRAM_W-1:0] map_swram7_mask = '0;
  logic [SWRAM_W-1:0] map_swram7_offset = '0;

  access_t pending_accesses[$];
  decode_t expected_decodes[$];
  int      mismatches = 0;
  logic    req_taken = 1'b0;
  int      burst_left = 0;
  int      gap_left = 0;

  dual_cpu_memory_region_decoder DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cpu_i          (cpu_i),
    .addr_i         (addr_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .region_code_o  (region_code_o),
    .mappable_o     (mappable_o),
    .mirror_start_o (mirror_start_o),
    .window_size_o  (window_size_o),
    .block_offset_o (block_offset_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic decode_t decode_addr(logic cpu, logic [ADDR_W-1:0] a);
    decode_t     d;
    logic [32:0] dtcm_end;
    logic [31:0] base;
    logic [31:0] win;
    logic [31:0] ofs;
    logic        map;
    d = '0;
    base = '0;
    win = '0;
    ofs = '0;
    map = 1'b1;
    dtcm_end = {1'b0, map_dtcm_base} + {7'b0, map_dtcm_size};
    if (!cpu) begin
      if (a < {6'b0, map_itcm_size}) d.region = RGN_ITCM;
      else if (a >= map_dtcm_base && {1'b0, a} < dtcm_end) d.region = RGN_DTCM;
      else if (a[31:12] == BIOS9_PAGE) d.region = RGN_BIOS9;
      else begin
        case (a[31:24])
          8'h02:   d.region = RGN_MAINRAM;
          8'h03:   d.region = (map_swram9_mask != 0) ? RGN_SWRAM : RGN_OTHER;
          8'h04:   d.region = RGN_IO9;
          8'h06:   d.region = RGN_VRAM;
          default: d.region = RGN_OTHER;
        endcase
      end
    end else begin
      if (a < BIOS7_LIMIT) d.region = RGN_BIOS7;
      else begin
        case (a[31:23])
          9'h004, 9'h005: d.region = RGN_MAINRAM;
          9'h006:         d.region = (map_swram7_mask != 0) ? RGN_SWRAM : RGN_WRAM7;
          9'h007:         d.region = RGN_WRAM7;
          9'h008:         d.region = RGN_IO7;
          9'h009:         d.region = RGN_WIFI;
          9'h00C, 9'h00D: d.region = RGN_VWRAM;
          default:        d.region = RGN_OTHER;
        endcase
      end
    end
    case (d.region)
      RGN_DTCM: begin
        base = map_dtcm_base;
        win = DTCM_PHYS_BYTES;
        ofs = MAIN_RAM_BYTES + SHARED_WRAM_BYTES + SECOND_WRAM_BYTES;
      end
      RGN_MAINRAM: begin
        base = MAIN_RAM_BASE;
        win = MAIN_RAM_BYTES;
        ofs = 0;
      end
      RGN_SWRAM: begin
        base = SWRAM_BASE;
        win = {17'b0, cpu ? map_swram7_mask : map_swram9_mask} + 32'd1;
        ofs = MAIN_RAM_BYTES + {17'b0, cpu ? map_swram7_offset : map_swram9_offset};
      end
      RGN_WRAM7: begin
        base = (map_swram7_mask != 0) ? WRAM7_HI_BASE : SWRAM_BASE;
        win = SECOND_WRAM_BYTES;
        ofs = MAIN_RAM_BYTES + SHARED_WRAM_BYTES;
      end
      default: map = 1'b0;
    endcase
    if (map && win != 0) begin
      d.mappable = 1'b1;
      d.mirror = ((a - base) / win) * win + base;
      d.window = win[WIN_W-1:0];
      d.offset = ofs[OFS_W-1:0];
    end
    return d;
  endfunction

  // request driver
  always @(negedge clk_i) begin : drive
    access_t nxt;
    logic    go;
    go = 1'b0;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!(start_i && !req_taken)) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_accesses.size() != 0) begin
        nxt = pending_accesses.pop_front();
        go = 1'b1;
        cpu_i <= nxt.cpu;
        addr_i <= nxt.addr;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
      start_i <= go;
    end
  end

  // result monitor and map shadow
  always @(posedge clk_i) begin : watch
    decode_t got;
    decode_t want;
    if (rst_ni) begin
      if (result_valid_o) begin
        got = '{region_code_o, mappable_o, mirror_start_o, window_size_o, block_offset_o};
        if (expected_decodes.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: region %0d map %b mirror %h win %h ofs %h",
                     got.region, got.mappable, got.mirror, got.window, got.offset);
          mismatches++;
        end else begin
          want = expected_decodes.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display({"mismatch: exp region %0d map %b mirror %h win %h ofs %h, ",
                        "got region %0d map %b mirror %h win %h ofs %h"},
                       want.region, want.mappable, want.mirror, want.window, want.offset,
                       got.region, got.mappable, got.mirror, got.window, got.offset);
            mismatches++;
          end
        end
      end
      if (start_i && !busy_o) expected_decodes.push_back(decode_addr(cpu_i, addr_i));
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_ITCM_SIZE:     map_itcm_size <= cfg_data_i[TCM_W-1:0];
          CFG_DTCM_BASE:     map_dtcm_base <= cfg_data_i;
          CFG_DTCM_SIZE:     map_dtcm_size <= cfg_data_i[TCM_W-1:0];
          CFG_SWRAM9_MASK:   map_swram9_mask <= cfg_data_i[SWRAM_W-1:0];
          CFG_SWRAM9_OFFSET: map_swram9_offset <= cfg_data_i[SWRAM_W-1:0];
          CFG_SWRAM7_MASK:   map_swram7_mask <= cfg_data_i[SWRAM_W-1:0];
          CFG_SWRAM7_OFFSET: map_swram7_offset <= cfg_data_i[SWRAM_W-1:0];
          default: ;
        endcase
      end
    end
    req_taken <= rst_ni && start_i && !busy_o;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // random junk above the register width checks masking
  function automatic logic [31:0] with_junk(logic [31:0] v, int w);
    logic [31:0] junk;
    junk = $urandom();
    return (junk << w) | v;
  endfunction

  task automatic set_map(input logic [TCM_W-1:0] itcm, input logic [ADDR_W-1:0] dbase,
                         input logic [TCM_W-1:0] dsize, input logic [SWRAM_W-1:0] m9,
                         input logic [SWRAM_W-1:0] o9, input logic [SWRAM_W-1:0] m7,
                         input logic [SWRAM_W-1:0] o7);
    write_reg(CFG_ITCM_SIZE, with_junk({6'b0, itcm}, TCM_W));
    write_reg(CFG_DTCM_BASE, dbase);
    write_reg(CFG_DTCM_SIZE, with_junk({6'b0, dsize}, TCM_W));
    write_reg(CFG_SWRAM9_MASK, with_junk({17'b0, m9}, SWRAM_W));
    write_reg(CFG_SWRAM9_OFFSET, with_junk({17'b0, o9}, SWRAM_W));
    write_reg(CFG_SWRAM7_MASK, with_junk({17'b0, m7}, SWRAM_W));
    write_reg(CFG_SWRAM7_OFFSET, with_junk({17'b0, o7}, SWRAM_W));
  endtask

  task automatic queue_access(input logic cpu, input logic [ADDR_W-1:0] a);
    pending_accesses.push_back('{cpu, a});
  endtask

  task automatic drain;
    @(posedge clk_i);
    while (pending_accesses.size() != 0 || start_i || expected_decodes.size() != 0)
      @(posedge clk_i);
    repeat (RESULT_LATENCY + 2) @(posedge clk_i);
  endtask

  function automatic logic [ADDR_W-1:0] pick_addr(logic cpu);
    logic [31:0] r;
    logic [7:0]  tops[8];
    tops = '{8'h00, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'hFF};
    r = $urandom();
    case ($urandom_range(0, 9))
      0, 1:    return r;
      2, 3, 4: return {tops[$urandom_range(0, 7)], r[23:0]};
      5:       return map_dtcm_base + (r % ({6'b0, map_dtcm_size} + 32'd64)) - 32'd32;
      6:       return (cpu ? BIOS7_LIMIT : {6'b0, map_itcm_size})
                      + $urandom_range(0, 63) - 32'd32;
      7:       return {16'hFFFF, r[15:0]};
      8:       return 32'h037F_FFE0 + $urandom_range(0, 63);
      default: return {tops[$urandom_range(0, 7)], 16'hFFFF, r[7:0]};
    endcase
  endfunction

  function automatic logic [TCM_W-1:0] pick_tcm_size();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return 26'd1 << $urandom_range(12, 25);
      2:       return 26'h200_0000;
      3:       return 26'h3FF_FFFF;
      default: return TCM_W'($urandom());
    endcase
  endfunction

  function automatic logic [SWRAM_W-1:0] pick_swram();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return (15'd1 << $urandom_range(10, 14)) - 15'd1;
      2:       return 15'h7FFF;
      default: return SWRAM_W'($urandom());
    endcase
  endfunction

  initial begin : stimulus
    logic [ADDR_W-1:0] dbase;
    logic              cpu;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // map as after reset
    queue_access(1'b0, 32'h0000_0000);
    queue_access(1'b0, 32'hFFFF_FFFF);
    queue_access(1'b0, 32'hFFFF_0000);
    queue_access(1'b0, 32'hFFFF_0FFF);
    queue_access(1'b0, 32'h0200_0000);
    queue_access(1'b0, 32'h02FF_FFFF);
    queue_access(1'b0, 32'h0300_0000);
    queue_access(1'b0, 32'h0400_0000);
    queue_access(1'b0, 32'h0600_0000);
    queue_access(1'b1, 32'h0000_3FFF);
    queue_access(1'b1, 32'h0000_4000);
    queue_access(1'b1, 32'h0280_0000);
    queue_access(1'b1, 32'h0300_0000);
    queue_access(1'b1, 32'h037F_FFFF);
    queue_access(1'b1, 32'h0380_0000);
    queue_access(1'b1, 32'h0480_0000);
    queue_access(1'b1, 32'h0680_0000);
    queue_access(1'b1, 32'hFFFF_FFFF);
    drain();

    // ITCM over DTCM, shared WRAM slice past the block, unused index ignored
    set_map(26'h200_0000, 32'h0000_4000, 26'h000_4000, 15'h7FFF, 15'h7FFF,
            15'h3FFF, 15'h4000);
    write_reg(CFG_UNUSED_IDX, 32'hFFFF_FFFF);
    queue_access(1'b0, 32'h0000_4000);
    queue_access(1'b0, 32'h01FF_FFFF);
    queue_access(1'b0, 32'h0300_1234);
    queue_access(1'b1, 32'h0300_0000);
    queue_access(1'b1, 32'h0380_0010);
    queue_access(1'b1, 32'h03FF_FFFF);
    drain();

    // DTCM over the BIOS page, window end past the address space
    set_map(26'h0, 32'hFFFF_0800, 26'h3FF_FFFF, 15'h0, 15'h0, 15'h0, 15'h0);
    queue_access(1'b0, 32'hFFFF_0000);
    queue_access(1'b0, 32'hFFFF_0800);
    queue_access(1'b0, 32'hFFFF_FFFF);
    drain();

    for (int phase = 0; phase < 11; phase++) begin
      if (phase == 0) begin
        for (int i = 0; i <= CFG_UNUSED_IDX; i++) write_reg(CFG_IDX_W'(i), 32'hFFFF_FFFF);
      end else if (phase == 1) begin
        for (int i = 0; i <= CFG_UNUSED_IDX; i++) write_reg(CFG_IDX_W'(i), 32'h0);
      end else begin
        case ($urandom_range(0, 3))
          0:       dbase = $urandom();
          1:       dbase = 32'h0280_0000;
          2:       dbase = 32'hFFFF_F000;
          default: dbase = $urandom() & 32'hFFFF_F000;
        endcase
        set_map(pick_tcm_size(), dbase, pick_tcm_size(), pick_swram(), pick_swram(),
                pick_swram(), pick_swram());
      end
      repeat (60) begin
        cpu = 1'($urandom_range(0, 1));
        queue_access(cpu, pick_addr(cpu));
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
